// File: sv/bsdo_pkg.sv
// ----------------------------------------------------------------------------
// bsdo_pkg
// Shared types and codes for the bounded drop-oldest record stack.
// ----------------------------------------------------------------------------
`default_nettype none

package bsdo_pkg;

   // operation codes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_PEEK  = 2'd3;

   // result status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_RECORD  = 2'd1;
   localparam logic [1:0] ST_EVICTED = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   localparam int unsigned NAME_W = 64;
   localparam int unsigned KIND_W = 8;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned OCC_W = 4;

   // one stored record
   typedef struct packed {
      logic        [NAME_W-1:0]  name_tag;
      logic        [KIND_W-1:0]  kind;
      logic signed [VALUE_W-1:0] value;
   } record_type;

endpackage

`default_nettype wire

// File: sv/bounded_stack_drop_oldest_core.sv
// ----------------------------------------------------------------------------
// bounded_stack_drop_oldest_core
// Bounded LIFO of records; a push onto a full stack evicts the oldest entry.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start/req_* and are taken when start is high and busy
//   is low. opcode selects push, pop, clear or peek; the record fields are
//   only used on push.
//   Every item gives exactly one result on rsp_*, marked by rsp_strobe
//   for one cycle, in the cycle after the item was taken. The receiver
//   cannot hold results off.
//   A new item cannot be taken while a result is out, because of the
//   registered read of the record RAM: the entry read at the accept edge
//   is returned (and, on an eviction, overwritten) in the following cycle,
//   during which busy is high.
//   Records live in a circular buffer in one RAM; a bottom pointer and a
//   count locate the oldest and newest entries, so an eviction just moves
//   the bottom pointer and reuses its slot for the new record.
//   Reset empties the stack at once (count cleared); the RAM is not cleared
//   and no entry is read before it has been written.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_drop_oldest_core #(
   parameter int unsigned STACK_DEPTH = 8
) (
   input  wire                 clock,
   input  wire                 reset,
   // item channel
   input  wire                 start,
   output logic                busy,
   input  wire  [1:0]          req_opcode,
   input  wire  [63:0]         req_name_tag,
   input  wire  [7:0]          req_kind,
   input  wire  signed [31:0]  req_value,
   // result channel
   output logic                rsp_strobe,
   output logic [1:0]          rsp_status,
   output logic [63:0]         rsp_out_name_tag,
   output logic [7:0]          rsp_out_kind,
   output logic signed [31:0]  rsp_out_value,
   output logic [3:0]          rsp_occupancy
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned SW = CW + 1;
   localparam int unsigned RW = $bits(bsdo_pkg::record_type);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
   localparam logic [SW-1:0] DEPTH_S = SW'(STACK_DEPTH);

   // control and payload registers
   logic                     busy_ff, busy_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            bottom_ff, bottom_in;
   logic [1:0]               status_ff, status_in;
   logic [AW-1:0]            addr_ff, addr_in;
   bsdo_pkg::record_type     rec_ff, rec_in;

   logic                     accept;
   bsdo_pkg::record_type     req_rec;
   logic [SW-1:0]            sum_top, sum_last;
   logic [AW-1:0]            slot_top, slot_last, bottom_next;
   logic                     full, empty;
   logic                     ram_wr_en, ram_rd_en;
   logic [AW-1:0]            ram_wr_addr, ram_rd_addr;
   bsdo_pkg::record_type     ram_wr_data;
   logic [RW-1:0]            ram_rd_data;
   bsdo_pkg::record_type     rd_rec;
   logic [CW+3:0]            occ_ext;

   assign accept = start && !busy_ff;
   assign full   = (count_ff == DEPTH_C);
   assign empty  = (count_ff == '0);

   assign req_rec.name_tag = req_name_tag;
   assign req_rec.kind     = req_kind;
   assign req_rec.value    = req_value;

   // circular slot arithmetic: sums stay below twice the depth
   always_comb begin
      sum_top  = SW'(bottom_ff) + SW'(count_ff);
      sum_last = sum_top - SW'(1);
      if (sum_top >= DEPTH_S) begin
         sum_top = sum_top - DEPTH_S;
      end
      if (sum_last >= DEPTH_S) begin
         sum_last = sum_last - DEPTH_S;
      end
      slot_top  = sum_top[AW-1:0];
      slot_last = sum_last[AW-1:0];
      if (SW'(bottom_ff) == DEPTH_S - SW'(1)) begin
         bottom_next = '0;
      end else begin
         bottom_next = bottom_ff + AW'(1);
      end
   end

   // item decode at the accept edge
   always_comb begin
      busy_in     = 1'b0;
      count_in    = count_ff;
      bottom_in   = bottom_ff;
      status_in   = status_ff;
      addr_in     = addr_ff;
      rec_in      = rec_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = slot_last;
      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_top;
      ram_wr_data = req_rec;
      if (busy_ff) begin
         // busy cycle: an eviction reuses the old bottom slot
         if (status_ff == bsdo_pkg::ST_EVICTED) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff;
            ram_wr_data = rec_ff;
         end
      end else if (accept) begin
         busy_in = 1'b1;
         case (req_opcode)
            bsdo_pkg::OP_PUSH: begin
               if (full) begin
                  status_in   = bsdo_pkg::ST_EVICTED;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = bottom_ff;
                  addr_in     = bottom_ff;
                  rec_in      = req_rec;
                  bottom_in   = bottom_next;
               end else begin
                  status_in = bsdo_pkg::ST_DONE;
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CW'(1);
               end
            end
            bsdo_pkg::OP_POP: begin
               if (empty) begin
                  status_in = bsdo_pkg::ST_EMPTY;
               end else begin
                  status_in = bsdo_pkg::ST_RECORD;
                  ram_rd_en = 1'b1;
                  count_in  = count_ff - CW'(1);
               end
            end
            bsdo_pkg::OP_CLEAR: begin
               status_in = bsdo_pkg::ST_DONE;
               count_in  = '0;
            end
            bsdo_pkg::OP_PEEK: begin
               if (empty) begin
                  status_in = bsdo_pkg::ST_EMPTY;
               end else begin
                  status_in = bsdo_pkg::ST_RECORD;
                  ram_rd_en = 1'b1;
               end
            end
            default: begin
               status_in = bsdo_pkg::ST_DONE;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         count_ff  <= '0;
         bottom_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         count_ff  <= count_in;
         bottom_ff <= bottom_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      addr_ff   <= addr_in;
      rec_ff    <= rec_in;
   end

   // record store
   bsdo_ram #(
      .WIDTH (RW),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result drive: record fields only for returned or evicted records
   assign rd_rec  = bsdo_pkg::record_type'(ram_rd_data);
   assign occ_ext = {4'd0, count_ff};

   always_comb begin
      busy          = busy_ff;
      rsp_strobe    = busy_ff;
      rsp_status    = status_ff;
      rsp_occupancy = occ_ext[3:0];
      if (status_ff == bsdo_pkg::ST_RECORD || status_ff == bsdo_pkg::ST_EVICTED) begin
         rsp_out_name_tag = rd_rec.name_tag;
         rsp_out_kind     = rd_rec.kind;
         rsp_out_value    = rd_rec.value;
      end else begin
         rsp_out_name_tag = '0;
         rsp_out_kind     = '0;
         rsp_out_value    = '0;
      end
   end

endmodule

`default_nettype wire

// File: sv/bsdo_ram.sv
// ----------------------------------------------------------------------------
// bsdo_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bsdo_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  wire                             clock,
   input  wire                             wr_en,
   input  wire  [$clog2(DEPTH)-1:0]        wr_addr,
   input  wire  [WIDTH-1:0]                wr_data,
   input  wire                             rd_en,
   input  wire  [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [WIDTH-1:0]                rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded drop-oldest record stack.
// ----------------------------------------------------------------------------
// A short table of directed items (empty errors, fill to the top, eviction
// of the oldest record, clear, extreme field values) is followed by about
// 1800 random items in phases biased towards filling, draining or a mix.
// A behavioural stack mirrors the block; every accepted item queues its
// expected result, and each strobed result is compared field by field with
// the oldest one queued. Items idle at random, apart from one long run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int DEPTH = 8;
   localparam int RANDOM_ITEMS = 1800;
   localparam int STALL_LIMIT = 2000;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [63:0]        name_tag;
      logic [7:0]         kind;
      logic signed [31:0] value;
      logic [3:0]         occupancy;
   } stack_reply_type;

   typedef struct {
      logic [1:0]         opcode;
      logic [63:0]        name_tag;
      logic [7:0]         kind;
      logic signed [31:0] value;
      bit                 typed;
      stack_reply_type    want;
   } cmd_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   wire                busy;
   logic [1:0]         req_opcode;
   logic [63:0]        req_name_tag;
   logic [7:0]         req_kind;
   logic signed [31:0] req_value;
   wire                rsp_strobe;
   wire  [1:0]         rsp_status;
   wire  [63:0]        rsp_out_name_tag;
   wire  [7:0]         rsp_out_kind;
   wire  signed [31:0] rsp_out_value;
   wire  [3:0]         rsp_occupancy;

   bounded_stack_drop_oldest_core #(
      .STACK_DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_name_tag(req_name_tag),
      .req_kind(req_kind),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_out_name_tag(rsp_out_name_tag),
      .rsp_out_kind(rsp_out_kind),
      .rsp_out_value(rsp_out_value),
      .rsp_occupancy(rsp_occupancy)
   );

   // mirror of the record store, index 0 is the oldest entry
   logic [63:0]        mirror_names [DEPTH];
   logic [7:0]         mirror_kinds [DEPTH];
   logic signed [31:0] mirror_values [DEPTH];
   int                 mirror_held = 0;

   stack_reply_type    pending_replies [$];
   cmd_row_type        directed_rows [$];
   bit                 row_typed = 1'b0;
   stack_reply_type    row_want = '0;
   bit                 gaps_on = 1'b1;
   int                 error_count = 0;
   int                 stall_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // apply one item to the mirror and return the result it should give
   function automatic stack_reply_type apply_stack_op(input logic [1:0] op,
                                                      input logic [63:0] nm,
                                                      input logic [7:0] kd,
                                                      input logic signed [31:0] vl);
      stack_reply_type r;
      int i;
      r = '0;
      case (op)
         bsdo_pkg::OP_PUSH: begin
            if (mirror_held == DEPTH) begin
               // full: report the oldest entry, slide the rest down
               r.status = bsdo_pkg::ST_EVICTED;
               r.name_tag = mirror_names[0];
               r.kind = mirror_kinds[0];
               r.value = mirror_values[0];
               for (i = 0; i < DEPTH - 1; i++) begin
                  mirror_names[i] = mirror_names[i+1];
                  mirror_kinds[i] = mirror_kinds[i+1];
                  mirror_values[i] = mirror_values[i+1];
               end
               mirror_names[DEPTH-1] = nm;
               mirror_kinds[DEPTH-1] = kd;
               mirror_values[DEPTH-1] = vl;
            end else begin
               mirror_names[mirror_held] = nm;
               mirror_kinds[mirror_held] = kd;
               mirror_values[mirror_held] = vl;
               mirror_held++;
               r.status = bsdo_pkg::ST_DONE;
            end
         end
         bsdo_pkg::OP_POP: begin
            if (mirror_held == 0) begin
               r.status = bsdo_pkg::ST_EMPTY;
            end else begin
               mirror_held--;
               r.status = bsdo_pkg::ST_RECORD;
               r.name_tag = mirror_names[mirror_held];
               r.kind = mirror_kinds[mirror_held];
               r.value = mirror_values[mirror_held];
            end
         end
         bsdo_pkg::OP_CLEAR: begin
            mirror_held = 0;
            r.status = bsdo_pkg::ST_DONE;
         end
         default: begin
            if (mirror_held == 0) begin
               r.status = bsdo_pkg::ST_EMPTY;
            end else begin
               r.status = bsdo_pkg::ST_RECORD;
               r.name_tag = mirror_names[mirror_held-1];
               r.kind = mirror_kinds[mirror_held-1];
               r.value = mirror_values[mirror_held-1];
            end
         end
      endcase
      r.occupancy = 4'(mirror_held);
      return r;
   endfunction

   // compare one strobed result with the oldest expectation
   task automatic check_reply();
      stack_reply_type want;
      if (pending_replies.size() == 0) begin
         $display("%0t: result with nothing expected, status %0d", $time, rsp_status);
         error_count++;
      end else begin
         want = pending_replies.pop_front();
         if (rsp_status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
            error_count++;
         end
         if (rsp_out_name_tag !== want.name_tag) begin
            $display("%0t: name_tag expected %h got %h",
                     $time, want.name_tag, rsp_out_name_tag);
            error_count++;
         end
         if (rsp_out_kind !== want.kind) begin
            $display("%0t: kind expected %h got %h", $time, want.kind, rsp_out_kind);
            error_count++;
         end
         if (rsp_out_value !== want.value) begin
            $display("%0t: value expected %0d got %0d", $time, want.value, rsp_out_value);
            error_count++;
         end
         if (rsp_occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d got %0d",
                     $time, want.occupancy, rsp_occupancy);
            error_count++;
         end
      end
   endtask

   // monitor: predict on every accepted item, then check any result
   always @(posedge clock) begin
      stack_reply_type got_pred;
      if (!reset) begin
         if (start && busy === 1'b0) begin
            got_pred = apply_stack_op(req_opcode, req_name_tag, req_kind, req_value);
            pending_replies.push_back(row_typed ? row_want : got_pred);
         end
         if (rsp_strobe !== 1'b0)
            check_reply();
         if ((start && busy === 1'b0) || rsp_strobe === 1'b1)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   // watchdog
   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
   end

   // drive one item from the falling edge until it is taken
   task automatic send_item(input cmd_row_type row);
      while (gaps_on && $urandom_range(0, 99) < 26) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_opcode <= row.opcode;
      req_name_tag <= row.name_tag;
      req_kind <= row.kind;
      req_value <= row.value;
      row_typed = row.typed;
      row_want = row.want;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   function automatic void add_row(input logic [1:0] op, input logic [63:0] nm,
                                   input logic [7:0] kd, input logic [31:0] vl,
                                   input bit typed, input logic [1:0] st,
                                   input logic [63:0] o_nm, input logic [7:0] o_kd,
                                   input logic [31:0] o_vl, input logic [3:0] occ);
      cmd_row_type row;
      row.opcode = op;
      row.name_tag = nm;
      row.kind = kd;
      row.value = vl;
      row.typed = typed;
      row.want = '{st, o_nm, o_kd, o_vl, occ};
      directed_rows.push_back(row);
   endfunction

   initial begin
      cmd_row_type row;
      op_mix_type mix;
      int roll;
      start = 1'b0;
      req_opcode = bsdo_pkg::OP_PUSH;
      req_name_tag = '0;
      req_kind = '0;
      req_value = '0;
      reset = 1'b1;

      // empty errors, fill, eviction of the oldest, clear, ignored fields
      add_row(bsdo_pkg::OP_POP, 64'h0, 8'h00, 32'h0,
              1, bsdo_pkg::ST_EMPTY, '0, '0, '0, 4'd0);
      add_row(bsdo_pkg::OP_PEEK, 64'h0, 8'h00, 32'h0,
              1, bsdo_pkg::ST_EMPTY, '0, '0, '0, 4'd0);
      add_row(bsdo_pkg::OP_CLEAR, 64'h0, 8'h00, 32'h0,
              1, bsdo_pkg::ST_DONE, '0, '0, '0, 4'd0);
      add_row(bsdo_pkg::OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'h8000_0000,
              1, bsdo_pkg::ST_DONE, '0, '0, '0, 4'd1);
      add_row(bsdo_pkg::OP_PUSH, 64'h0, 8'h00, 32'h7FFF_FFFF,
              1, bsdo_pkg::ST_DONE, '0, '0, '0, 4'd2);
      add_row(bsdo_pkg::OP_PEEK, 64'h0, 8'h00, 32'h0,
              1, bsdo_pkg::ST_RECORD, 64'h0, 8'h00, 32'h7FFF_FFFF, 4'd2);
      add_row(bsdo_pkg::OP_POP, 64'h0, 8'h00, 32'h0,
              1, bsdo_pkg::ST_RECORD, 64'h0, 8'h00, 32'h7FFF_FFFF, 4'd1);
      add_row(bsdo_pkg::OP_PUSH, 64'h0123_4567_89AB_CDEF, 8'h41, 32'hFFFF_FFFF,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      add_row(bsdo_pkg::OP_PUSH, 64'h1111_1111_1111_1111, 8'h01, 32'h1,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      add_row(bsdo_pkg::OP_PUSH, 64'h2222_2222_2222_2222, 8'h02, 32'h2,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      add_row(bsdo_pkg::OP_PUSH, 64'h3333_3333_3333_3333, 8'h03, 32'h3,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      add_row(bsdo_pkg::OP_PUSH, 64'h4444_4444_4444_4444, 8'h04, 32'h4,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      add_row(bsdo_pkg::OP_PUSH, 64'h5555_5555_5555_5555, 8'h05, 32'h5,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      add_row(bsdo_pkg::OP_PUSH, 64'h6666_6666_6666_6666, 8'h06, 32'h6,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      // stack now full: the next pushes evict the oldest records
      add_row(bsdo_pkg::OP_PUSH, 64'h7777_7777_7777_7777, 8'h07, 32'h7,
              1, bsdo_pkg::ST_EVICTED,
              64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'h8000_0000, 4'd8);
      add_row(bsdo_pkg::OP_PUSH, 64'h8888_8888_8888_8888, 8'h08, 32'h8,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      add_row(bsdo_pkg::OP_PEEK, 64'h0, 8'h00, 32'h0,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      add_row(bsdo_pkg::OP_POP, 64'h0, 8'h00, 32'h0,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      add_row(bsdo_pkg::OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
              1, bsdo_pkg::ST_DONE, '0, '0, '0, 4'd0);
      add_row(bsdo_pkg::OP_POP, 64'h0, 8'h00, 32'h0,
              1, bsdo_pkg::ST_EMPTY, '0, '0, '0, 4'd0);
      add_row(bsdo_pkg::OP_PEEK, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'h8000_0000,
              1, bsdo_pkg::ST_EMPTY, '0, '0, '0, 4'd0);
      add_row(bsdo_pkg::OP_PUSH, 64'h5555_5555_5555_5555, 8'hAA, 32'h0,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      add_row(bsdo_pkg::OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 32'h5555_5555,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      add_row(bsdo_pkg::OP_PEEK, 64'h0, 8'h00, 32'h0,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);
      add_row(bsdo_pkg::OP_POP, 64'h0, 8'h00, 32'h0,
              0, bsdo_pkg::ST_DONE, '0, '0, '0, '0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i]);

      // random phases; one long run without idle cycles
      mix = MIX_EVEN;
      row.typed = 1'b0;
      row.want = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0)
            mix = op_mix_type'($urandom_range(0, 2));
         gaps_on = !(n >= 700 && n < 1000);
         roll = $urandom_range(0, 99);
         case (mix)
            MIX_FILL:  row.opcode = roll < 65 ? bsdo_pkg::OP_PUSH :
                                    roll < 82 ? bsdo_pkg::OP_POP :
                                    roll < 96 ? bsdo_pkg::OP_PEEK : bsdo_pkg::OP_CLEAR;
            MIX_DRAIN: row.opcode = roll < 30 ? bsdo_pkg::OP_PUSH :
                                    roll < 80 ? bsdo_pkg::OP_POP :
                                    roll < 96 ? bsdo_pkg::OP_PEEK : bsdo_pkg::OP_CLEAR;
            default:   row.opcode = roll < 45 ? bsdo_pkg::OP_PUSH :
                                    roll < 75 ? bsdo_pkg::OP_POP :
                                    roll < 93 ? bsdo_pkg::OP_PEEK : bsdo_pkg::OP_CLEAR;
         endcase
         row.name_tag = {$urandom(), $urandom()};
         row.kind = 8'($urandom_range(0, 255));
         row.value = $urandom();
         // now and then an extreme value
         case ($urandom_range(0, 9))
            0: row.value = 32'sh8000_0000;
            1: row.value = 32'sh7FFF_FFFF;
            2: row.name_tag = '1;
            3: row.kind = '0;
            default: ;
         endcase
         send_item(row);
      end

      start <= 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
sv/bsdo_pkg.sv
sv/bsdo_ram.sv
sv/bounded_stack_drop_oldest_core.sv
tb/sv/tb_top.sv
